// File: rtl/core/temperature_compensation_unit_defines.svh
// Assertion macros shared by the temperature compensation RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH
`define TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("temperature compensation check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("temperature compensation check failed");

`endif

// File: rtl/core/tcu_pkg.sv
// Package for the temperature compensation unit: widths, shift constants,
// configuration register indexes and the sideband type that rides with each request.
`default_nettype none
package tcu_pkg;

  localparam int RAW_W     = 16;
  localparam int CAL_W     = 16;
  localparam int DIFF_W    = 17;
  localparam int PROD_W    = 34;
  localparam int X1_W      = 18;
  localparam int DEN_W     = 19;
  localparam int NUM_W     = 27;
  localparam int QS_W      = 28;
  localparam int SUM_W     = 29;
  localparam int OUT_W     = 24;
  localparam int SHIFT_X1  = 15;
  localparam int SHIFT_MC  = 11;
  localparam int SHIFT_OUT = 4;
  localparam int ROUND_ADD = 8;
  localparam int X1_LIMIT  = 131069;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_AC5 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AC6 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MC  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MD  = 2'd3;

  typedef struct packed {
    logic                   dz;
    logic                   qneg;
    logic signed [X1_W-1:0] x1;
  } tcu_side_t;

endpackage
`default_nettype wire

// File: rtl/core/tcu_offset.sv
// Front pipeline: offset, gain multiply and divisor/numerator preparation.
// Depends on tcu_pkg and the shared assertion macro header.
`default_nettype none
module tcu_offset (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  input  wire         [tcu_pkg::RAW_W-1:0]     raw_temp,
  input  wire         [tcu_pkg::CAL_W-1:0]     cal_ac5,
  input  wire         [tcu_pkg::CAL_W-1:0]     cal_ac6,
  input  wire  signed [tcu_pkg::CAL_W-1:0]     cal_mc,
  input  wire  signed [tcu_pkg::CAL_W-1:0]     cal_md,
  output logic                                 out_valid,
  output tcu_pkg::tcu_side_t                   side,
  output logic        [tcu_pkg::DEN_W-1:0]     den_mag,
  output logic        [tcu_pkg::NUM_W-1:0]     num_mag
);
  import tcu_pkg::*;
  `include "temperature_compensation_unit_defines.svh"

  logic                     v1;
  logic                     v2;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [DIFF_W-1:0] gain;
  logic signed [X1_W-1:0]   x1;
  logic signed [DEN_W-1:0]  den;
  logic signed [NUM_W-1:0]  num;

  assign gain = $signed({1'b0, cal_ac5});
  assign x1   = prod[SHIFT_X1 +: X1_W];
  assign den  = DEN_W'(x1) + DEN_W'(cal_md);
  assign num  = {cal_mc, {SHIFT_MC{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    diff      <= $signed({1'b0, raw_temp}) - $signed({1'b0, cal_ac6});
    prod      <= PROD_W'(diff) * PROD_W'(gain);
    den_mag   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    num_mag   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    side.dz   <= (den == '0);
    side.qneg <= den[DEN_W-1] ^ num[NUM_W-1];
    side.x1   <= x1;
  end

  `TCU_ASSERT_NOW(a_x1_bound, v2, (x1 <= X1_LIMIT) && (x1 >= -X1_LIMIT))

endmodule
`default_nettype wire

// File: rtl/core/tcu_div.sv
// Pipelined restoring divider, one quotient bit per stage, on magnitudes.
// Depends on tcu_pkg and the shared assertion macro header.
`default_nettype none
module tcu_div (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  input  tcu_pkg::tcu_side_t               side_in,
  input  wire        [tcu_pkg::DEN_W-1:0]  den_mag,
  input  wire        [tcu_pkg::NUM_W-1:0]  num_mag,
  output logic                             out_valid,
  output tcu_pkg::tcu_side_t               side_out,
  output logic       [tcu_pkg::NUM_W-1:0]  quo_mag
);
  import tcu_pkg::*;
  `include "temperature_compensation_unit_defines.svh"

  logic             v_q    [0:NUM_W-1];
  tcu_side_t        side_q [0:NUM_W-1];
  logic [DEN_W-1:0] rem_q  [0:NUM_W-1];
  logic [DEN_W-1:0] den_q  [0:NUM_W-1];
  logic [NUM_W-1:0] num_q  [0:NUM_W-1];
  logic [NUM_W-1:0] quo_q  [0:NUM_W-1];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             v_in;
    tcu_side_t        s_in;
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [NUM_W-1:0] n_in;
    logic [NUM_W-1:0] q_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign s_in = side_in;
      assign r_in = '0;
      assign d_in = den_mag;
      assign n_in = num_mag;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign s_in = side_q[k-1];
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign n_in = num_q[k-1];
      assign q_in = quo_q[k-1];
    end

    assign trial = {r_in, n_in[NUM_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      side_q[k] <= s_in;
      den_q[k]  <= d_in;
      num_q[k]  <= {n_in[NUM_W-2:0], 1'b0};
      quo_q[k]  <= {q_in[NUM_W-2:0], ge};
      rem_q[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign out_valid = v_q[NUM_W-1];
  assign side_out  = side_q[NUM_W-1];
  assign quo_mag   = quo_q[NUM_W-1];

  `TCU_ASSERT_NOW(a_rem_below_divisor, v_q[NUM_W-1] && !side_q[NUM_W-1].dz,
                  rem_q[NUM_W-1] < den_q[NUM_W-1])

endmodule
`default_nettype wire

// File: rtl/core/temperature_compensation_unit.sv
// Top level of the temperature compensation unit: calibration registers,
// front pipeline, divider and output stages. Depends on tcu_pkg, tcu_offset, tcu_div.
//
// Usage: write the four calibration words through cfg_we, cfg_index and cfg_data
// (index 0 ac5, 1 ac6, 2 mc, 3 md) while no request is in flight. A request is
// taken at a rising edge with start high and busy low; busy stays low, so a new
// raw_temp sample may be issued in every cycle.
// Each request yields one result: done rises and stays high for exactly one cycle,
// with temp_tenths and div_by_zero valid in that cycle. The pipeline is the 27-stage
// divider, one quotient bit per stage, plus three front stages and two output stages.
// Throughput is one request per cycle.
// A zero divisor gives temp_tenths of zero with div_by_zero set.
// The receiver cannot stall, so results flow out in the order requests came in.
// Reset clears the calibration words to zero and drops every request in flight.
`default_nettype none
module temperature_compensation_unit (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  input  wire         [tcu_pkg::RAW_W-1:0]      raw_temp,
  input  wire                                   cfg_we,
  input  wire         [tcu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire         [tcu_pkg::CAL_W-1:0]      cfg_data,
  output logic                                  done,
  output logic signed [tcu_pkg::OUT_W-1:0]      temp_tenths,
  output logic                                  div_by_zero
);
  import tcu_pkg::*;
  `include "temperature_compensation_unit_defines.svh"

  logic        [CAL_W-1:0] cal_ac5;
  logic        [CAL_W-1:0] cal_ac6;
  logic signed [CAL_W-1:0] cal_mc;
  logic signed [CAL_W-1:0] cal_md;

  logic                    off_valid;
  tcu_side_t               off_side;
  logic        [DEN_W-1:0] off_den;
  logic        [NUM_W-1:0] off_num;

  logic                    div_valid;
  tcu_side_t               div_side;
  logic        [NUM_W-1:0] div_quo;

  logic                    fin_valid;
  logic                    fin_dz;
  logic signed [X1_W-1:0]  fin_x1;
  logic signed [QS_W-1:0]  fin_q;
  logic signed [SUM_W-1:0] sum;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac5 <= '0;
      cal_ac6 <= '0;
      cal_mc  <= '0;
      cal_md  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AC5: cal_ac5 <= cfg_data;
        CFG_AC6: cal_ac6 <= cfg_data;
        CFG_MC:  cal_mc  <= $signed(cfg_data);
        CFG_MD:  cal_md  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  tcu_offset u_offset (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .raw_temp  (raw_temp),
    .cal_ac5   (cal_ac5),
    .cal_ac6   (cal_ac6),
    .cal_mc    (cal_mc),
    .cal_md    (cal_md),
    .out_valid (off_valid),
    .side      (off_side),
    .den_mag   (off_den),
    .num_mag   (off_num)
  );

  tcu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (off_valid),
    .side_in   (off_side),
    .den_mag   (off_den),
    .num_mag   (off_num),
    .out_valid (div_valid),
    .side_out  (div_side),
    .quo_mag   (div_quo)
  );

  assign sum = SUM_W'(fin_x1) + SUM_W'(fin_q) + SUM_W'(ROUND_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      fin_valid <= div_valid;
      done      <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    fin_dz      <= div_side.dz;
    fin_x1      <= div_side.x1;
    fin_q       <= div_side.qneg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    temp_tenths <= fin_dz ? '0 : sum[SHIFT_OUT +: OUT_W];
    div_by_zero <= fin_dz;
  end

  `TCU_ASSERT_NOW(a_zero_forces_zero, done && div_by_zero, temp_tenths == '0)
  `TCU_ASSERT_NEXT(a_done_follows_final, fin_valid, done)

endmodule
`default_nettype wire

// File: tb/tb_temperature_compensation_unit.sv
// Self-checking testbench for temperature_compensation_unit: directed table, then random
// calibration sets and raw samples; each result is checked against the table or an in-bench predictor.
// Depends on tcu_pkg and the temperature_compensation_unit RTL only.
`timescale 1ns / 1ps

module tb_temperature_compensation_unit;
  import tcu_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] t;
    logic                    dz;
  } reading_t;

  typedef struct packed {
    logic [CAL_W-1:0]        ac5;
    logic [CAL_W-1:0]        ac6;
    logic [CAL_W-1:0]        mc;
    logic [CAL_W-1:0]        md;
    logic [RAW_W-1:0]        raw;
    logic                    typed;
    logic signed [OUT_W-1:0] t;
    logic                    dz;
  } row_t;

  localparam int NUM_ROWS = 20;
  localparam int RANDOM_REQUESTS = 1650;
  localparam int SETTLE_CYCLES = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [RAW_W-1:0]    raw_temp = '0;
  logic                cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0]    cfg_data = '0;
  logic                busy;
  logic                done;
  logic signed [OUT_W-1:0] temp_tenths;
  logic                div_by_zero;

  logic [CAL_W-1:0] ac5_q = '0;
  logic [CAL_W-1:0] ac6_q = '0;
  logic [CAL_W-1:0] mc_q = '0;
  logic [CAL_W-1:0] md_q = '0;

  reading_t pending_readings [$];
  reading_t want;
  int mismatches = 0;
  int requests_sent = 0;
  int readings_seen = 0;
  int zero_div_seen = 0;
  int cal_sets = 0;

  // Extremes first, then zero-divisor cases, then divide sign and truncation cases.
  row_t directed_rows [NUM_ROWS] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 24'sd0, 1'b1},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 24'sd0, 1'b1},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 1'b1, 24'sd0, 1'b0},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b1, 24'sd0, 1'b0},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 24'sd0, 1'b0},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 24'sd0, 1'b1},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 24'sd0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 24'sd0, 1'b1},
    '{16'h8000, 16'h0000, 16'h0000, 16'hFF9C, 16'd100, 1'b1, 24'sd0, 1'b1},
    '{16'h8000, 16'h0000, 16'h0000, 16'hFF9C, 16'd101, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 16'h0000, 16'h7FFF, 16'h0001, 16'h1234, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 16'h0000, 16'h8000, 16'h0001, 16'h1234, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 16'h5A5A, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'hA5A5, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 16'h0000, 16'h0001, 16'hFFFD, 16'h0005, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 16'h0000, 16'hFFFF, 16'h0003, 16'h0005, 1'b0, 24'sd0, 1'b0},
    '{16'h8000, 16'h1234, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 24'sd0, 1'b0},
    '{16'h8000, 16'h1234, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 24'sd0, 1'b0},
    '{16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 1'b0, 24'sd0, 1'b0},
    '{16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 1'b0, 24'sd0, 1'b0}
  };

  temperature_compensation_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .raw_temp    (raw_temp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .temp_tenths (temp_tenths),
    .div_by_zero (div_by_zero)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The offset product is floored by an arithmetic shift; the quotient truncates toward zero.
  function automatic reading_t compensate_temp(input logic [RAW_W-1:0] raw);
    reading_t r;
    longint x1;
    longint den;
    longint num;
    longint sum;
    x1 = ((longint'(raw) - longint'(ac6_q)) * longint'(ac5_q)) >>> SHIFT_X1;
    den = x1 + longint'($signed(md_q));
    num = longint'($signed(mc_q)) * (longint'(1) << SHIFT_MC);
    if (den == 0) begin
      r.t = '0;
      r.dz = 1'b1;
    end else begin
      sum = (x1 + num / den + ROUND_ADD) >>> SHIFT_OUT;
      r.t = sum[OUT_W-1:0];
      r.dz = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [CAL_W-1:0] pick_cal();
    case ($urandom_range(6))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'($urandom_range(63));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void flag_error(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic program_cal(input logic [CAL_W-1:0] a5, input logic [CAL_W-1:0] a6,
                             input logic [CAL_W-1:0] c, input logic [CAL_W-1:0] d);
    logic [CAL_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    vals = '{a5, a6, c, d};
    idxs = '{CFG_AC5, CFG_AC6, CFG_MC, CFG_MD};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ac5_q = a5;
    ac6_q = a6;
    mc_q = c;
    md_q = d;
    cal_sets++;
  endtask

  task automatic idle_some(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      raw_temp <= RAW_W'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic issue_request(input logic [RAW_W-1:0] raw, input reading_t expect_r);
    start <= 1'b1;
    raw_temp <= raw;
    do @(posedge clk); while (busy);
    pending_readings.push_back(expect_r);
    requests_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        flag_error($sformatf("result %0d / %0b with none expected", temp_tenths, div_by_zero));
      end else begin
        want = pending_readings.pop_front();
        if (want.dz) zero_div_seen++;
        if (temp_tenths !== want.t || div_by_zero !== want.dz) begin
          flag_error($sformatf("result %0d: expected %0d / %0b, got %0d / %0b",
                               readings_seen, want.t, want.dz, temp_tenths, div_by_zero));
        end
      end
    end
  end

  initial begin
    #(12 * 300000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    row_t row;
    reading_t expect_r;
    logic [CAL_W-1:0] a5, a6, c, d;
    logic [RAW_W-1:0] target, raw;
    longint x1t;
    int n;
    int phase_len;
    int pct;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first rows run on the reset calibration, so nothing is written before them.
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = directed_rows[i];
      if ({row.ac5, row.ac6, row.mc, row.md} != {ac5_q, ac6_q, mc_q, md_q}) begin
        wait_drained();
        program_cal(row.ac5, row.ac6, row.mc, row.md);
      end
      idle_some(27);
      if (row.typed) begin
        expect_r.t = row.t;
        expect_r.dz = row.dz;
      end else begin
        expect_r = compensate_temp(row.raw);
      end
      issue_request(row.raw, expect_r);
    end

    n = 0;
    while (n < RANDOM_REQUESTS) begin
      phase_len = $urandom_range(70, 15);
      a5 = pick_cal();
      a6 = pick_cal();
      c = pick_cal();
      d = pick_cal();
      target = RAW_W'($urandom);
      // Often tune md so that one sample value lands exactly on a zero divisor.
      if ($urandom_range(1) == 1) begin
        x1t = ((longint'(target) - longint'(a6)) * longint'(a5)) >>> SHIFT_X1;
        if (x1t >= -32767 && x1t <= 32768) d = CAL_W'(-x1t);
      end
      wait_drained();
      program_cal(a5, a6, c, d);
      for (int k = 0; k < phase_len && n < RANDOM_REQUESTS; k++) begin
        if (n < RANDOM_REQUESTS / 3) pct = 27;
        else if (n < 2 * RANDOM_REQUESTS / 3) pct = 78;
        else pct = 0;
        idle_some(pct);
        raw = ($urandom_range(7) == 0) ? target : RAW_W'($urandom);
        issue_request(raw, compensate_temp(raw));
        n++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0) flag_error("expected results never arrived");

    $display("summary: %0d requests over %0d calibration sets, %0d results, %0d zero divisors",
             requests_sent, cal_sets, readings_seen, zero_div_seen);
    $display("summary: %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
